// ===== hdl/fais_pkg.sv =====
// Shared types and codes for the fixed array insert/delete/search core.
`timescale 1ns / 1ps
`default_nettype none
package fais_pkg;

    localparam logic [2:0] KIND_INSERT  = 3'd0;
    localparam logic [2:0] KIND_DELETE  = 3'd1;
    localparam logic [2:0] KIND_REVERSE = 3'd2;
    localparam logic [2:0] KIND_SEARCH  = 3'd3;
    localparam logic [2:0] KIND_DISPLAY = 3'd4;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_BADPOS   = 2'd1;
    localparam logic [1:0] ST_NOTFOUND = 2'd2;

    typedef struct packed {
        logic [2:0]         kind;
        logic [3:0]         position;
        logic signed [31:0] value;
    } item_t;

    typedef struct packed {
        logic [1:0]         status;
        logic [3:0]         found_slot;
        logic signed [31:0] entry;
        logic               last;
    } result_t;

endpackage
`default_nettype wire

// ===== hdl/fais_ram.sv =====
// Generic single write port, single read port RAM with registered read.
`timescale 1ns / 1ps
`default_nettype none
module fais_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

// ===== hdl/fixed_array_insert_delete_search_core.sv =====
// Fixed array of signed words with insert, delete, reverse, search and display.
//
// Items come in on item/item_valid/item_ready, results leave on
// result/result_valid/result_ready; a transfer happens when valid and ready
// are both high. item_ready is high only while the sequencer is idle; one
// item is worked on at a time. The words live in one RAM with a single read
// and a single write port. Every entry that an operation moves, swaps,
// compares or shows is read through that port, which sets the time per
// item. Insert and delete shift the entries from position p on, reverse
// swaps pairs, search scans up to the first match or the last entry, and
// display gives DEPTH results, one per entry.
// The next item is taken in the idle state that follows each item.
// Results go through an output register, so a new item is taken while the
// last result still waits; a stalled receiver holds the sequencer only when
// it has another result to hand over. Reset clears the state, the result
// valid flag and a per-entry valid vector; entries never written read as
// zero, so the store is all zero right after reset with no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
module fixed_array_insert_delete_search_core #(
    parameter int DEPTH = 8
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              item_valid,
    output logic                   item_ready,
    input  wire fais_pkg::item_t   item,
    output logic                   result_valid,
    input  wire logic              result_ready,
    output fais_pkg::result_t      result
);
    import fais_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
    localparam logic [AW-1:0] HALF_LAST = AW'(DEPTH / 2 - 1);
    localparam logic [AW-1:0] ONE_IDX = AW'(1);
    localparam logic [31:0] DEPTH_W = 32'(DEPTH);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_INS_RD   = 4'd1;
    localparam logic [3:0] S_INS_WR   = 4'd2;
    localparam logic [3:0] S_INS_PUT  = 4'd3;
    localparam logic [3:0] S_DEL_RD   = 4'd4;
    localparam logic [3:0] S_DEL_WR   = 4'd5;
    localparam logic [3:0] S_DEL_CLR  = 4'd6;
    localparam logic [3:0] S_REV_RDA  = 4'd7;
    localparam logic [3:0] S_REV_RDB  = 4'd8;
    localparam logic [3:0] S_REV_WRA  = 4'd9;
    localparam logic [3:0] S_REV_WRB  = 4'd10;
    localparam logic [3:0] S_SRCH_RD  = 4'd11;
    localparam logic [3:0] S_SRCH_CMP = 4'd12;
    localparam logic [3:0] S_DSP_RD   = 4'd13;
    localparam logic [3:0] S_DSP_OUT  = 4'd14;
    localparam logic [3:0] S_EMIT     = 4'd15;

    logic [3:0]         state_reg, state_next;
    logic [AW-1:0]      idx_reg, idx_next;
    logic [AW-1:0]      pidx_reg, pidx_next;
    logic signed [31:0] val_reg, val_next;
    logic [31:0]        tmp_reg, tmp_next;
    result_t            res_reg, res_next;
    result_t            result_reg, result_next;
    logic               result_valid_reg, result_valid_next;
    logic [DEPTH-1:0]   valid_reg;
    logic               rd_valid_reg;

    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    logic [31:0]        ram_wdata;
    logic [AW-1:0]      ram_raddr;
    logic [31:0]        ram_rdata;
    logic [31:0]        rdata;
    logic [AW-1:0]      hi_idx;
    logic [AW-1:0]      item_pidx;
    logic [3:0]         slot;
    logic               pos_ok;
    logic               can_emit;
    logic               emit;
    result_t            pending;

    fais_ram #(
        .WIDTH (32),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // entries never written read as zero
    assign rdata     = rd_valid_reg ? ram_rdata : 32'd0;
    assign hi_idx    = LAST_IDX - idx_reg;
    assign item_pidx = AW'({28'd0, item.position} - 32'd1);
    assign slot      = 4'({{(32-AW){1'b0}}, idx_reg} + 32'd1);
    assign pos_ok    = (item.position != 4'd0) && ({28'd0, item.position} <= DEPTH_W);
    assign can_emit  = !result_valid_reg || result_ready;

    assign item_ready   = (state_reg == S_IDLE);
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        pidx_next  = pidx_reg;
        val_next   = val_reg;
        tmp_next   = tmp_reg;
        res_next   = res_reg;
        ram_we     = 1'b0;
        ram_waddr  = idx_reg;
        ram_wdata  = rdata;
        ram_raddr  = idx_reg;
        emit       = 1'b0;
        pending    = res_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    val_next  = item.value;
                    pidx_next = item_pidx;
                    res_next  = '{status: ST_OK, found_slot: 4'd0, entry: 32'sd0, last: 1'b1};
                    idx_next  = '0;
                    state_next = S_EMIT;
                    case (item.kind)
                        KIND_INSERT:
                        begin
                            if (!pos_ok)
                            begin
                                res_next.status = ST_BADPOS;
                            end
                            else
                            begin
                                idx_next = LAST_IDX;
                                state_next = (item_pidx == LAST_IDX) ? S_INS_PUT : S_INS_RD;
                            end
                        end
                        KIND_DELETE:
                        begin
                            if (!pos_ok)
                            begin
                                res_next.status = ST_BADPOS;
                            end
                            else
                            begin
                                idx_next = item_pidx;
                                state_next = (item_pidx == LAST_IDX) ? S_DEL_CLR : S_DEL_RD;
                            end
                        end
                        KIND_REVERSE: state_next = S_REV_RDA;
                        KIND_SEARCH:  state_next = S_SRCH_RD;
                        KIND_DISPLAY: state_next = S_DSP_RD;
                        default:      state_next = S_EMIT;
                    endcase
                end
            end
            S_INS_RD:
            begin
                ram_raddr  = idx_reg - ONE_IDX;
                state_next = S_INS_WR;
            end
            S_INS_WR:
            begin
                ram_we    = 1'b1;
                ram_waddr = idx_reg;
                ram_wdata = rdata;
                idx_next  = idx_reg - ONE_IDX;
                state_next = (idx_reg - ONE_IDX == pidx_reg) ? S_INS_PUT : S_INS_RD;
            end
            S_INS_PUT:
            begin
                ram_we     = 1'b1;
                ram_waddr  = pidx_reg;
                ram_wdata  = val_reg;
                state_next = S_EMIT;
            end
            S_DEL_RD:
            begin
                ram_raddr  = idx_reg + ONE_IDX;
                state_next = S_DEL_WR;
            end
            S_DEL_WR:
            begin
                ram_we    = 1'b1;
                ram_waddr = idx_reg;
                ram_wdata = rdata;
                idx_next  = idx_reg + ONE_IDX;
                state_next = (idx_reg + ONE_IDX == LAST_IDX) ? S_DEL_CLR : S_DEL_RD;
            end
            S_DEL_CLR:
            begin
                ram_we     = 1'b1;
                ram_waddr  = LAST_IDX;
                ram_wdata  = 32'd0;
                state_next = S_EMIT;
            end
            S_REV_RDA:
            begin
                ram_raddr  = idx_reg;
                state_next = S_REV_RDB;
            end
            S_REV_RDB:
            begin
                ram_raddr  = hi_idx;
                tmp_next   = rdata;
                state_next = S_REV_WRA;
            end
            S_REV_WRA:
            begin
                ram_we     = 1'b1;
                ram_waddr  = idx_reg;
                ram_wdata  = rdata;
                state_next = S_REV_WRB;
            end
            S_REV_WRB:
            begin
                ram_we    = 1'b1;
                ram_waddr = hi_idx;
                ram_wdata = tmp_reg;
                idx_next  = idx_reg + ONE_IDX;
                state_next = (idx_reg == HALF_LAST) ? S_EMIT : S_REV_RDA;
            end
            S_SRCH_RD:
            begin
                ram_raddr  = idx_reg;
                state_next = S_SRCH_CMP;
            end
            S_SRCH_CMP:
            begin
                if (rdata == val_reg)
                begin
                    res_next.found_slot = slot;
                    state_next = S_EMIT;
                end
                else if (idx_reg == LAST_IDX)
                begin
                    res_next.status = ST_NOTFOUND;
                    state_next = S_EMIT;
                end
                else
                begin
                    idx_next   = idx_reg + ONE_IDX;
                    state_next = S_SRCH_RD;
                end
            end
            S_DSP_RD:
            begin
                ram_raddr  = idx_reg;
                state_next = S_DSP_OUT;
            end
            S_DSP_OUT:
            begin
                // read address held on idx so the word stays put while stalled
                pending = '{status: ST_OK, found_slot: slot, entry: rdata,
                            last: (idx_reg == LAST_IDX)};
                if (can_emit)
                begin
                    emit = 1'b1;
                    if (idx_reg == LAST_IDX)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        idx_next   = idx_reg + ONE_IDX;
                        state_next = S_DSP_RD;
                    end
                end
            end
            S_EMIT:
            begin
                if (can_emit)
                begin
                    emit       = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        result_next       = result_reg;
        result_valid_next = result_valid_reg;
        if (emit)
        begin
            result_next       = pending;
            result_valid_next = 1'b1;
        end
        else if (result_ready)
        begin
            result_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            result_valid_reg <= 1'b0;
            valid_reg        <= '0;
            rd_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            result_valid_reg <= result_valid_next;
            if (ram_we)
            begin
                valid_reg[ram_waddr] <= 1'b1;
            end
            rd_valid_reg <= valid_reg[ram_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg    <= idx_next;
        pidx_reg   <= pidx_next;
        val_reg    <= val_next;
        tmp_reg    <= tmp_next;
        res_reg    <= res_next;
        result_reg <= result_next;
    end

endmodule
`default_nettype wire

// ===== dv/fixed_array_insert_delete_search_core_tb.sv =====
// Self-checking testbench for the fixed array insert/delete/reverse/search core.
`timescale 1ns / 1ps
module fixed_array_insert_delete_search_core_tb;
    import fais_pkg::*;

    localparam int DEPTH = 8;
    localparam int RANDOM_ITEMS = 145;
    localparam logic [2:0] KIND_SPARE_LO = 3'd5;
    localparam logic [2:0] KIND_SPARE_HI = 3'd7;

    // Shadow copy of the array plus the queue of results it predicts.
    class array_shadow;
        logic signed [31:0] shadow_words [DEPTH];
        result_t            awaited_reports [$];
        int                 mismatches;
        int                 reports_seen;
        int                 search_hits;
        int                 bad_positions;
        int                 kinds_seen [8];

        function new();
            foreach (shadow_words[i]) shadow_words[i] = '0;
            mismatches = 0;
            reports_seen = 0;
            search_hits = 0;
            bad_positions = 0;
            foreach (kinds_seen[i]) kinds_seen[i] = 0;
        endfunction

        function int pending();
            return awaited_reports.size();
        endfunction

        // Apply one accepted item to the shadow and queue what it should produce.
        function void apply_item(item_t it);
            result_t r;
            int      p;
            int      i;
            logic signed [31:0] t;
            r = '0;
            r.status = ST_OK;
            r.last = 1'b1;
            p = it.position;
            kinds_seen[it.kind]++;
            case (it.kind)
                KIND_INSERT, KIND_DELETE:
                begin
                    if (p < 1 || p > DEPTH) begin
                        r.status = ST_BADPOS;
                        bad_positions++;
                    end else if (it.kind == KIND_INSERT) begin
                        for (i = DEPTH - 1; i >= p; i--)
                            shadow_words[i] = shadow_words[i - 1];
                        shadow_words[p - 1] = it.value;
                    end else begin
                        for (i = p; i < DEPTH; i++)
                            shadow_words[i - 1] = shadow_words[i];
                        shadow_words[DEPTH - 1] = '0;
                    end
                    awaited_reports.push_back(r);
                end
                KIND_REVERSE:
                begin
                    for (i = 0; i < DEPTH / 2; i++) begin
                        t = shadow_words[i];
                        shadow_words[i] = shadow_words[DEPTH - 1 - i];
                        shadow_words[DEPTH - 1 - i] = t;
                    end
                    awaited_reports.push_back(r);
                end
                KIND_SEARCH:
                begin
                    r.status = ST_NOTFOUND;
                    // lowest matching slot wins
                    for (i = 0; i < DEPTH; i++) begin
                        if (shadow_words[i] == it.value) begin
                            r.status = ST_OK;
                            r.found_slot = 4'(i + 1);
                            search_hits++;
                            break;
                        end
                    end
                    awaited_reports.push_back(r);
                end
                KIND_DISPLAY:
                begin
                    for (i = 0; i < DEPTH; i++) begin
                        r.found_slot = 4'(i + 1);
                        r.entry = shadow_words[i];
                        r.last = (i == DEPTH - 1);
                        awaited_reports.push_back(r);
                    end
                end
                default:
                    awaited_reports.push_back(r);
            endcase
        endfunction

        function void compare_field(string name, longint want, longint got);
            if (want != got) begin
                mismatches++;
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            end
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (awaited_reports.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected result, expected none, actual %p", $time, got);
                return;
            end
            want = awaited_reports.pop_front();
            reports_seen++;
            compare_field("status", want.status, got.status);
            compare_field("found_slot", want.found_slot, got.found_slot);
            compare_field("entry", want.entry, got.entry);
            compare_field("last", want.last, got.last);
        endfunction
    endclass

    logic    clk;
    logic    rst_n;
    logic    item_valid;
    logic    item_ready;
    item_t   item_bus;
    logic    result_valid;
    logic    result_ready;
    result_t result_bus;

    array_shadow shadow;
    bit          tx_no_gap;
    bit          rx_no_stall;

    fixed_array_insert_delete_search_core #(.DEPTH(DEPTH)) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item_bus),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result_bus)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n && item_valid && item_ready)
            shadow.apply_item(item_bus);
        if (rst_n && result_valid && result_ready)
            shadow.check_result(result_bus);
    end

    function automatic item_t make_item(logic [2:0] k, logic [3:0] p, logic signed [31:0] v);
        item_t it;
        it.kind = k;
        it.position = p;
        it.value = v;
        return it;
    endfunction

    function automatic item_t make_random_item();
        int         roll;
        logic [2:0] k;
        logic [3:0] p;
        logic signed [31:0] v;
        roll = $urandom_range(0, 99);
        if (roll < 35)      k = KIND_INSERT;
        else if (roll < 52) k = KIND_DELETE;
        else if (roll < 60) k = KIND_REVERSE;
        else if (roll < 85) k = KIND_SEARCH;
        else if (roll < 93) k = KIND_DISPLAY;
        else                k = 3'($urandom_range(KIND_SPARE_LO, KIND_SPARE_HI));
        // mostly legal slots, sometimes zero or past the end
        if ($urandom_range(0, 99) < 85)
            p = 4'($urandom_range(1, DEPTH));
        else
            p = 4'($urandom_range(0, 15));
        roll = $urandom_range(0, 99);
        // a narrow pool keeps searches hitting and duplicates likely
        if (roll < 45)      v = 32'(int'($urandom_range(0, 8)) - 4);
        else if (roll < 80) v = $urandom;
        else if (roll < 90) v = 32'sh8000_0000;
        else                v = 32'sh7fff_ffff;
        return make_item(k, p, v);
    endfunction

    // Called at a falling edge; returns at the falling edge after the transfer.
    task automatic send_item(item_t it);
        int gap;
        gap = tx_no_gap ? 0 : $urandom_range(0, 19);
        if (gap > 0) begin
            item_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        item_bus <= it;
        item_valid <= 1'b1;
        @(posedge clk);
        while (!item_ready) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic drain_results();
        item_valid <= 1'b0;
        while (shadow.pending() != 0) @(negedge clk);
        repeat (3) @(negedge clk);
    endtask

    initial
    begin
        int stall;
        result_ready = 1'b0;
        @(posedge rst_n);
        forever begin
            @(negedge clk);
            stall = rx_no_stall ? 0 : $urandom_range(0, 19);
            if (stall > 0) begin
                result_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            result_ready <= 1'b1;
            @(posedge clk);
            while (!result_valid) @(posedge clk);
        end
    end

    initial
    begin
        item_t directed [$];
        int    n;
        shadow = new();
        tx_no_gap = 1'b0;
        rx_no_stall = 1'b0;
        rst_n = 1'b0;
        item_valid = 1'b0;
        item_bus = '0;
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        directed.push_back(make_item(KIND_DISPLAY, 4'd0, 32'sd0));
        directed.push_back(make_item(KIND_SEARCH, 4'd0, 32'sd0));
        directed.push_back(make_item(KIND_SEARCH, 4'd15, 32'sd5));
        directed.push_back(make_item(KIND_INSERT, 4'd1, 32'sh7fff_ffff));
        directed.push_back(make_item(KIND_INSERT, 4'(DEPTH), 32'sh8000_0000));
        directed.push_back(make_item(KIND_INSERT, 4'd0, 32'sd11));
        directed.push_back(make_item(KIND_INSERT, 4'(DEPTH + 1), 32'sd12));
        directed.push_back(make_item(KIND_INSERT, 4'd15, -32'sd1));
        directed.push_back(make_item(KIND_INSERT, 4'd2, 32'sd7));
        directed.push_back(make_item(KIND_INSERT, 4'd4, 32'sd7));
        directed.push_back(make_item(KIND_SEARCH, 4'd9, 32'sd7));
        directed.push_back(make_item(KIND_SEARCH, 4'd3, 32'sh8000_0000));
        directed.push_back(make_item(KIND_DISPLAY, 4'd15, -32'sd1));
        directed.push_back(make_item(KIND_REVERSE, 4'd15, 32'sh5a5a_a5a5));
        directed.push_back(make_item(KIND_DISPLAY, 4'd0, 32'sd0));
        directed.push_back(make_item(KIND_DELETE, 4'd1, -32'sd1));
        directed.push_back(make_item(KIND_DELETE, 4'(DEPTH), 32'sd0));
        directed.push_back(make_item(KIND_DELETE, 4'd0, 32'sd0));
        directed.push_back(make_item(KIND_DELETE, 4'd15, 32'sd0));
        directed.push_back(make_item(KIND_SPARE_LO, 4'd3, 32'sd9));
        directed.push_back(make_item(3'(KIND_SPARE_LO + 1), 4'd0, -32'sd1));
        directed.push_back(make_item(KIND_SPARE_HI, 4'd15, 32'sh7fff_ffff));
        directed.push_back(make_item(KIND_SEARCH, 4'd0, 32'sh7fff_ffff));
        directed.push_back(make_item(KIND_DISPLAY, 4'd0, 32'sd0));
        foreach (directed[i]) send_item(directed[i]);
        drain_results();

        for (n = 0; n < RANDOM_ITEMS; n++) begin
            // back-to-back stretches, one with the receiver never stalling
            tx_no_gap = (n >= 40 && n < 70) || (n >= 100 && n < 120);
            rx_no_stall = (n >= 40 && n < 70);
            if (n == 85)
                drain_results();
            send_item(make_random_item());
        end
        rx_no_stall = 1'b0;
        drain_results();
        repeat (20) @(negedge clk);

        $display("covered %0d inserts, %0d deletes, %0d reverses, %0d searches, %0d displays",
            shadow.kinds_seen[KIND_INSERT], shadow.kinds_seen[KIND_DELETE],
            shadow.kinds_seen[KIND_REVERSE], shadow.kinds_seen[KIND_SEARCH],
            shadow.kinds_seen[KIND_DISPLAY]);
        $display("%0d results compared, %0d search hits, %0d bad positions, %0d mismatches",
            shadow.reports_seen, shadow.search_hits, shadow.bad_positions,
            shadow.mismatches);
        if (shadow.mismatches == 0 && shadow.pending() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        #3_000_000;
        $display("timeout with %0d results outstanding", shadow.pending());
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
